[sv/rnse_pkg.sv]
// Shared types and constants for the RRT nearest-node / steer block.
// No dependencies; imported by rnse_div and rrt_nearest_steer_extend.
`default_nettype none
package rnse_pkg;

    localparam int unsigned RNSE_MAX_NODES = 256;
    localparam int unsigned COORD_W  = 20;
    localparam int unsigned DIFF_W   = COORD_W + 1;
    localparam int unsigned SQ_W     = 2 * DIFF_W;
    localparam int unsigned ROOT_W   = DIFF_W;
    localparam int unsigned STEP_W   = 16;
    localparam int unsigned PAR_W    = 8;
    localparam int unsigned NIDX_W   = 9;
    // numerator 2*m*step + dist, denominator 2*dist
    localparam int unsigned NUM_W    = 38;
    localparam int unsigned DEN_W    = ROOT_W + 1;

    typedef enum logic [1:0] {
        FUNC_ROOT    = 2'd0,
        FUNC_PROPOSE = 2'd1,
        FUNC_COMMIT  = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_NOHELD = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHECK,
        ST_SQRT,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_EMIT
    } t_state;

endpackage
`default_nettype wire

[sv/rrt_nearest_steer_extend.sv]
// Top level of the RRT tree-extension block: node memory, nearest scan, steer.
// Depends on rnse_pkg and rnse_div.
//
// Root and commit words go from acceptance straight to the emit state. A propose
// word scans the node memory one entry per cycle through its single read port
// and a four-stage distance pipeline, then goes to emit when the sample lies
// within max_step. A clipped step adds a bit-serial square root and two
// bit-serial divisions (one per axis, each with its set-up in ST_MUL) plus a
// final state, ST_FIN, to form the point. One word is worked on at a time; a
// new word is taken as soon as the previous result sits in the output register.
// No clearing pass: the node memory is only read below the fill count.
`default_nettype none
module rrt_nearest_steer_extend #(
    parameter int unsigned MAX_NODES = rnse_pkg::RNSE_MAX_NODES
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [rnse_pkg::STEP_W-1:0] i_cfg_data,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [1:0]                  i_func,
    input  wire logic signed [rnse_pkg::COORD_W-1:0] i_sample_x,
    input  wire logic signed [rnse_pkg::COORD_W-1:0] i_sample_y,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic signed [rnse_pkg::COORD_W-1:0] o_new_x,
    output logic signed [rnse_pkg::COORD_W-1:0] o_new_y,
    output logic [rnse_pkg::PAR_W-1:0]       o_parent_index,
    output logic [rnse_pkg::NIDX_W-1:0]      o_node_index,
    output logic                             o_was_clipped,
    output logic [1:0]                       o_status
);
    import rnse_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_NODES);
    localparam int unsigned CNT_W = $clog2(MAX_NODES + 1);
    localparam int unsigned SQC_W = $clog2(ROOT_W);

    t_state r_state, n_state;

    logic [STEP_W-1:0]          r_max_step;
    logic [2*STEP_W-1:0]        r_step2;
    logic [CNT_W-1:0]           r_count;
    logic signed [COORD_W-1:0]  r_held_x, r_held_y;
    logic [PAR_W-1:0]           r_held_parent;
    logic                       r_held_valid;
    logic signed [COORD_W-1:0]  r_sx, r_sy;

    // node memory: {x, y}
    logic [2*COORD_W-1:0] r_mem [MAX_NODES];
    logic [2*COORD_W-1:0] r_rd_data;
    logic                 w_we;
    logic [IDX_W-1:0]     w_waddr;
    logic [2*COORD_W-1:0] w_wdata;

    // scan pipeline
    logic [CNT_W-1:0]          r_issue;
    logic                      w_issue;
    logic                      r_p1, r_p2, r_p3;
    logic [IDX_W-1:0]          r_p1_idx, r_p2_idx, r_p3_idx;
    logic signed [DIFF_W-1:0]  r_ex, r_ey;
    logic signed [COORD_W-1:0] r_p2_x, r_p2_y, r_p3_x, r_p3_y;
    logic [SQ_W-1:0]           r_sqx, r_sqy;
    logic [SQ_W-1:0]           w_d2;
    logic [DIFF_W-1:0]         w_mex, w_mey;
    logic [IDX_W-1:0]          r_best_idx;
    logic [SQ_W-1:0]           r_best_d2;
    logic signed [COORD_W-1:0] r_best_x, r_best_y;

    // square root
    logic [SQ_W-1:0]    r_sq_n;
    logic [ROOT_W+2:0]  r_sq_rem;
    logic [ROOT_W-1:0]  r_sq_root;
    logic [SQC_W-1:0]   r_sq_cnt;
    logic [ROOT_W+2:0]  w_sq_sh, w_sq_trial;
    logic               w_sq_ge;

    // steer
    logic                      r_axis;
    logic signed [DIFF_W-1:0]  w_dx, w_dy;
    logic [DIFF_W-1:0]         w_m;
    logic [DIFF_W+STEP_W-1:0]  w_prod;
    logic [NUM_W-1:0]          r_num;
    logic                      r_div_start;
    logic                      w_div_done;
    logic [NUM_W-1:0]          w_quot;
    logic [DIFF_W-1:0]         r_qx;
    logic signed [DIFF_W-1:0]  w_px, w_py, w_offx, w_offy;

    // result staging
    logic signed [COORD_W-1:0] r_res_x, r_res_y;
    logic [PAR_W-1:0]          r_res_par;
    logic [NIDX_W-1:0]         r_res_idx;
    logic                      r_res_clip;
    t_status                   r_res_stat;

    logic                      w_acc;
    logic                      w_full;
    logic                      w_scan_done;
    logic                      w_emit;
    logic [PAR_W-1:0]          w_best_par;
    logic [NIDX_W-1:0]         w_count_idx;
    logic [IDX_W+PAR_W-1:0]    w_best_ext;
    logic [CNT_W+NIDX_W-1:0]   w_count_ext;

    assign w_acc       = i_in_valid && o_in_ready;
    assign w_full      = (r_count == CNT_W'(MAX_NODES));
    assign w_best_ext  = {{PAR_W{1'b0}}, r_best_idx};
    assign w_best_par  = w_best_ext[PAR_W-1:0];
    assign w_count_ext = {{NIDX_W{1'b0}}, r_count};
    assign w_count_idx = w_count_ext[NIDX_W-1:0];
    assign w_emit      = (r_state == ST_EMIT) && (!o_out_valid || i_out_ready);

    // ---------------- node memory ----------------
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_count[IDX_W-1:0];
        w_wdata = {r_held_x, r_held_y};
        if (w_acc && i_func == FUNC_ROOT) begin
            w_we    = 1'b1;
            w_waddr = '0;
            w_wdata = {i_sample_x, i_sample_y};
        end else if (w_acc && i_func == FUNC_COMMIT && r_held_valid && !w_full) begin
            w_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[r_issue[IDX_W-1:0]];
    end

    // ---------------- next state ----------------
    assign w_issue     = (r_state == ST_SCAN) && (r_issue < r_count);
    assign w_scan_done = (r_issue == r_count) && !r_p1 && !r_p2 && !r_p3;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    unique case (i_func)
                        FUNC_ROOT, FUNC_COMMIT: n_state = ST_EMIT;
                        FUNC_PROPOSE: n_state = (r_count == '0) ? ST_EMIT : ST_SCAN;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN:  if (w_scan_done) n_state = ST_CHECK;
            ST_CHECK: n_state = (r_best_d2 > SQ_W'(r_step2)) ? ST_SQRT : ST_EMIT;
            ST_SQRT:  if (r_sq_cnt == SQC_W'(ROOT_W - 1)) n_state = ST_MUL;
            ST_MUL:   n_state = ST_DIV;
            ST_DIV:   if (w_div_done) n_state = r_axis ? ST_FIN : ST_MUL;
            ST_FIN:   n_state = ST_EMIT;
            ST_EMIT:  if (w_emit) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // ---------------- outputs of the state machine ----------------
    always_comb begin
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            default: o_in_ready = 1'b0;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_max_step    <= STEP_W'(1024);
            r_count       <= '0;
            r_held_valid  <= 1'b0;
            r_held_x      <= '0;
            r_held_y      <= '0;
            r_held_parent <= '0;
            r_p1          <= 1'b0;
            r_p2          <= 1'b0;
            r_p3          <= 1'b0;
            r_issue       <= '0;
            r_div_start   <= 1'b0;
            r_axis        <= 1'b0;
            o_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_start <= (r_state == ST_MUL);
            if (i_cfg_we) r_max_step <= i_cfg_data;

            r_p1 <= w_issue;
            r_p2 <= r_p1;
            r_p3 <= r_p2;
            if (w_issue) r_issue <= r_issue + 1'b1;

            if (w_acc) begin
                case (i_func)
                    FUNC_ROOT: begin
                        r_count      <= CNT_W'(1);
                        r_held_valid <= 1'b0;
                    end
                    FUNC_PROPOSE: begin
                        r_issue <= '0;
                        if (r_count == '0) r_held_valid <= 1'b0;
                    end
                    FUNC_COMMIT: begin
                        if (r_held_valid) begin
                            r_held_valid <= 1'b0;
                            if (!w_full) r_count <= r_count + 1'b1;
                        end
                    end
                    default: ;
                endcase
            end

            if (r_state == ST_CHECK && n_state == ST_EMIT) begin
                r_held_x      <= r_sx;
                r_held_y      <= r_sy;
                r_held_parent <= w_best_par;
                r_held_valid  <= 1'b1;
            end
            if (r_state == ST_FIN) begin
                r_held_x      <= w_px[COORD_W-1:0];
                r_held_y      <= w_py[COORD_W-1:0];
                r_held_parent <= w_best_par;
                r_held_valid  <= 1'b1;
            end

            if (r_state == ST_SQRT) r_axis <= 1'b0;
            if (r_state == ST_DIV && w_div_done) r_axis <= 1'b1;

            if (w_emit) o_out_valid <= 1'b1;
            else if (i_out_ready) o_out_valid <= 1'b0;
        end
    end

    // ---------------- scan datapath ----------------
    assign w_mex = r_ex[DIFF_W-1] ? DIFF_W'(-r_ex) : DIFF_W'(r_ex);
    assign w_mey = r_ey[DIFF_W-1] ? DIFF_W'(-r_ey) : DIFF_W'(r_ey);
    assign w_d2  = r_sqx + r_sqy;

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_sx <= i_sample_x;
            r_sy <= i_sample_y;
        end
        r_p1_idx <= r_issue[IDX_W-1:0];
        // stage 2: differences
        r_p2_idx <= r_p1_idx;
        r_p2_x   <= r_rd_data[2*COORD_W-1:COORD_W];
        r_p2_y   <= r_rd_data[COORD_W-1:0];
        r_ex     <= DIFF_W'(r_sx) - DIFF_W'(signed'(r_rd_data[2*COORD_W-1:COORD_W]));
        r_ey     <= DIFF_W'(r_sy) - DIFF_W'(signed'(r_rd_data[COORD_W-1:0]));
        // stage 3: squares
        r_p3_idx <= r_p2_idx;
        r_p3_x   <= r_p2_x;
        r_p3_y   <= r_p2_y;
        r_sqx    <= w_mex * w_mex;
        r_sqy    <= w_mey * w_mey;
        // stage 4: keep the nearest, lowest index on a tie
        if (r_p3 && (r_p3_idx == '0 || w_d2 < r_best_d2)) begin
            r_best_idx <= r_p3_idx;
            r_best_d2  <= w_d2;
            r_best_x   <= r_p3_x;
            r_best_y   <= r_p3_y;
        end
        r_step2 <= r_max_step * r_max_step;
    end

    // ---------------- square root, two bits of d2 per cycle ----------------
    assign w_sq_sh    = {r_sq_rem[ROOT_W:0], r_sq_n[SQ_W-1:SQ_W-2]};
    assign w_sq_trial = {1'b0, r_sq_root, 2'b01};
    assign w_sq_ge    = (w_sq_sh >= w_sq_trial);

    always_ff @(posedge i_clk) begin
        if (r_state == ST_CHECK) begin
            r_sq_n    <= r_best_d2;
            r_sq_rem  <= '0;
            r_sq_root <= '0;
            r_sq_cnt  <= '0;
        end else if (r_state == ST_SQRT) begin
            r_sq_n    <= {r_sq_n[SQ_W-3:0], 2'b00};
            r_sq_rem  <= w_sq_ge ? (w_sq_sh - w_sq_trial) : w_sq_sh;
            r_sq_root <= {r_sq_root[ROOT_W-2:0], w_sq_ge};
            r_sq_cnt  <= r_sq_cnt + 1'b1;
        end
    end

    // ---------------- steer ----------------
    assign w_dx = DIFF_W'(r_sx) - DIFF_W'(r_best_x);
    assign w_dy = DIFF_W'(r_sy) - DIFF_W'(r_best_y);
    always_comb begin
        if (r_axis) w_m = w_dy[DIFF_W-1] ? DIFF_W'(-w_dy) : DIFF_W'(w_dy);
        else        w_m = w_dx[DIFF_W-1] ? DIFF_W'(-w_dx) : DIFF_W'(w_dx);
    end

    // full-width product before doubling
    assign w_prod = w_m * r_max_step;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_MUL) begin
            r_num <= NUM_W'({w_prod, 1'b0}) + NUM_W'(r_sq_root);
        end
        if (r_state == ST_DIV && w_div_done && !r_axis) begin
            r_qx <= w_quot[DIFF_W-1:0];
        end
    end

    rnse_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_num),
        .i_den   ({r_sq_root, 1'b0}),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // y quotient is taken straight from the divider in ST_FIN
    assign w_offx = w_dx[DIFF_W-1] ? DIFF_W'(-r_qx) : DIFF_W'(r_qx);
    assign w_offy = w_dy[DIFF_W-1] ? DIFF_W'(-w_quot[DIFF_W-1:0])
                                   : DIFF_W'(w_quot[DIFF_W-1:0]);
    assign w_px   = DIFF_W'(r_best_x) + w_offx;
    assign w_py   = DIFF_W'(r_best_y) + w_offy;

    // ---------------- result staging and output register ----------------
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_res_clip <= 1'b0;
            case (i_func)
                FUNC_ROOT: begin
                    r_res_x    <= i_sample_x;
                    r_res_y    <= i_sample_y;
                    r_res_par  <= '0;
                    r_res_idx  <= '0;
                    r_res_stat <= STAT_OK;
                end
                FUNC_COMMIT: begin
                    r_res_idx <= w_count_idx;
                    r_res_x   <= r_held_valid ? r_held_x : '0;
                    r_res_y   <= r_held_valid ? r_held_y : '0;
                    r_res_par <= r_held_valid ? r_held_parent : '0;
                    if (!r_held_valid) r_res_stat <= STAT_NOHELD;
                    else if (w_full)   r_res_stat <= STAT_FULL;
                    else               r_res_stat <= STAT_OK;
                end
                default: begin
                    r_res_x    <= i_sample_x;
                    r_res_y    <= i_sample_y;
                    r_res_par  <= '0;
                    r_res_idx  <= w_count_idx;
                    r_res_stat <= STAT_OK;
                end
            endcase
        end
        if (r_state == ST_CHECK) begin
            r_res_par <= w_best_par;
        end
        if (r_state == ST_FIN) begin
            r_res_x    <= w_px[COORD_W-1:0];
            r_res_y    <= w_py[COORD_W-1:0];
            r_res_clip <= 1'b1;
        end
        if (w_emit) begin
            o_new_x        <= r_res_x;
            o_new_y        <= r_res_y;
            o_parent_index <= r_res_par;
            o_node_index   <= r_res_idx;
            o_was_clipped  <= r_res_clip;
            o_status       <= r_res_stat;
        end
    end

    // ---------------- checks ----------------
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_NODES))
        else $error("node count beyond table depth");
    a_root_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_func == FUNC_ROOT) |=> (r_count == CNT_W'(1)))
        else $error("root word did not reset the tree");
    a_pipe_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p1 || r_p2 || r_p3) |-> (r_state == ST_SCAN))
        else $error("scan pipeline busy outside the scan");
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> (r_state == ST_DIV && $past(r_state) == ST_MUL))
        else $error("divider started outside the steer sequence");
    a_scan_read_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue |-> (r_issue < r_count && r_count != '0))
        else $error("scan reads beyond the filled nodes");

endmodule
`default_nettype wire

[sv/rnse_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Uses rnse_pkg for the operand widths.
`default_nettype none
module rnse_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [rnse_pkg::NUM_W-1:0] i_num,
    input  wire logic [rnse_pkg::DEN_W-1:0] i_den,
    output logic                            o_done,
    output logic [rnse_pkg::NUM_W-1:0]      o_quot
);
    import rnse_pkg::*;

    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_quot;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic             r_done;
    logic [DEN_W:0]   w_sh;
    logic             w_ge;

    assign w_sh = {r_rem, r_num[NUM_W-1]};
    assign w_ge = (w_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == CNT_W'(NUM_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[NUM_W-2:0], 1'b0};
            r_rem  <= w_ge ? DEN_W'(w_sh - {1'b0, r_den}) : w_sh[DEN_W-1:0];
            r_quot <= {r_quot[NUM_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

    // remainder must stay below the divisor between steps
    a_rem_lt_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start && r_cnt != '0) |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");
    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done held for two cycles");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(r_busy))
        else $error("divider done without a division running");

endmodule
`default_nettype wire
